@@ design/tlv_pkg.sv @@
// ----------------------------------------------------------------------------
// tlv_pkg
// Types and constants shared by the TLV stream parser modules.
// ----------------------------------------------------------------------------
package tlv_pkg;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_VAL
    } tlv_phase_t;

    localparam logic [1:0] KIND_INT   = 2'd0;
    localparam logic [1:0] KIND_RAW   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_TRUNC = 2'd3;

    localparam logic [0:0] REG_BUF_LEN = 1'b0;

    localparam int HDR_LEN_BYTES = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [31:0] length;
        logic [31:0] int_value;
        logic [7:0]  value_byte;
        logic        last_of_record;
    } tlv_result_t;

endpackage

@@ design/tlv_apb.sv @@
// ----------------------------------------------------------------------------
// tlv_apb
// Configuration register port holding the buffer length.
// ----------------------------------------------------------------------------
module tlv_apb (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] buffer_length
);

    logic [31:0] blen_reg;
    logic [31:0] blen_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        blen_next = blen_reg;
        if (wr_en && (paddr[2] == tlv_pkg::REG_BUF_LEN))
        begin
            blen_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blen_reg <= 32'd0;
        end
        else
        begin
            blen_reg <= blen_next;
        end
    end

    assign prdata        = (paddr[2] == tlv_pkg::REG_BUF_LEN) ? blen_reg : 32'd0;
    assign buffer_length = blen_reg;

endmodule

@@ design/tlv_core.sv @@
// ----------------------------------------------------------------------------
// tlv_core
// Per-byte parse state machine. Each accepted byte updates the record state
// and may produce one result.
// ----------------------------------------------------------------------------
module tlv_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                first_of_buffer,
    input  logic [31:0]         buffer_length,
    output logic                res_valid,
    output tlv_pkg::tlv_result_t res
);

    tlv_pkg::tlv_phase_t ph_reg, ph_next, ph_eff;
    logic [32:0] off_reg, off_next, off_eff, off_inc;
    logic [7:0]  tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] cnt_reg, cnt_next, cnt_inc;
    logic [31:0] acc_reg, acc_next;
    logic        stp_reg, stp_next, stp_eff;

    logic [31:0] byte_shift;
    logic [31:0] len_shift;
    logic [31:0] acc_shift;
    logic        tag_end;
    logic        hdr_trunc;
    logic        val_trunc;
    logic        is_short;
    logic        val_done;
    logic        len_done;

    assign ph_eff  = first_of_buffer ? tlv_pkg::PH_TAG : ph_reg;
    assign off_eff = first_of_buffer ? 33'd0 : off_reg;
    assign stp_eff = first_of_buffer ? 1'b0 : stp_reg;
    assign off_inc = off_eff + 33'd1;
    assign cnt_inc = cnt_reg + 32'd1;

    assign byte_shift = {24'd0, data_byte} << {cnt_reg[1:0], 3'b000};
    assign len_shift  = len_reg | byte_shift;
    assign acc_shift  = acc_reg | byte_shift;

    assign tag_end   = off_eff >= {1'b0, buffer_length};
    assign hdr_trunc = ({1'b0, off_inc} + 34'(tlv_pkg::HDR_LEN_BYTES))
                       > {2'b00, buffer_length};
    assign val_trunc = ({1'b0, off_inc} + {2'b00, len_shift}) > {2'b00, buffer_length};
    assign is_short  = (len_reg == 32'd1) || (len_reg == 32'd2) || (len_reg == 32'd4);
    assign val_done  = cnt_inc >= len_reg;
    assign len_done  = cnt_inc >= 32'(tlv_pkg::HDR_LEN_BYTES);

    always_comb
    begin
        ph_next  = ph_reg;
        off_next = off_reg;
        tag_next = tag_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        stp_next = stp_reg;
        if (accept)
        begin
            ph_next  = ph_eff;
            off_next = off_eff;
            stp_next = stp_eff;
            if (!stp_eff)
            begin
                case (ph_eff)
                    tlv_pkg::PH_TAG:
                    begin
                        if (tag_end)
                        begin
                            stp_next = 1'b1;
                        end
                        else
                        begin
                            tag_next = data_byte;
                            len_next = 32'd0;
                            cnt_next = 32'd0;
                            acc_next = 32'd0;
                            off_next = off_inc;
                            if (hdr_trunc)
                            begin
                                stp_next = 1'b1;
                            end
                            else
                            begin
                                ph_next = tlv_pkg::PH_LEN;
                            end
                        end
                    end
                    tlv_pkg::PH_LEN:
                    begin
                        len_next = len_shift;
                        off_next = off_inc;
                        cnt_next = cnt_inc;
                        if (len_done)
                        begin
                            cnt_next = 32'd0;
                            acc_next = 32'd0;
                            if (val_trunc)
                            begin
                                stp_next = 1'b1;
                            end
                            else if (len_shift == 32'd0)
                            begin
                                ph_next = tlv_pkg::PH_TAG;
                            end
                            else
                            begin
                                ph_next = tlv_pkg::PH_VAL;
                            end
                        end
                    end
                    tlv_pkg::PH_VAL:
                    begin
                        off_next = off_inc;
                        cnt_next = cnt_inc;
                        if (is_short)
                        begin
                            acc_next = acc_shift;
                        end
                        if (val_done)
                        begin
                            ph_next = tlv_pkg::PH_TAG;
                        end
                    end
                    default:
                    begin
                        ph_next = tlv_pkg::PH_TAG;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_valid          = 1'b0;
        res.kind           = tlv_pkg::KIND_TRUNC;
        res.tag            = tag_reg;
        res.length         = 32'd0;
        res.int_value      = 32'd0;
        res.value_byte     = 8'd0;
        res.last_of_record = 1'b1;
        if (accept && !stp_eff)
        begin
            case (ph_eff)
                tlv_pkg::PH_TAG:
                begin
                    res.tag = data_byte;
                    if (!tag_end && hdr_trunc)
                    begin
                        res_valid = 1'b1;
                    end
                end
                tlv_pkg::PH_LEN:
                begin
                    if (len_done)
                    begin
                        if (val_trunc)
                        begin
                            res_valid  = 1'b1;
                            res.length = len_shift;
                        end
                        else if (len_shift == 32'd0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = tlv_pkg::KIND_EMPTY;
                        end
                    end
                end
                tlv_pkg::PH_VAL:
                begin
                    res.length = len_reg;
                    if (is_short)
                    begin
                        res.kind      = tlv_pkg::KIND_INT;
                        res.int_value = acc_shift;
                        res_valid     = val_done;
                    end
                    else
                    begin
                        res_valid          = 1'b1;
                        res.kind           = tlv_pkg::KIND_RAW;
                        res.value_byte     = data_byte;
                        res.last_of_record = val_done;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= tlv_pkg::PH_TAG;
            off_reg <= 33'd0;
            tag_reg <= 8'd0;
            len_reg <= 32'd0;
            cnt_reg <= 32'd0;
            acc_reg <= 32'd0;
            stp_reg <= 1'b0;
        end
        else
        begin
            ph_reg  <= ph_next;
            off_reg <= off_next;
            tag_reg <= tag_next;
            len_reg <= len_next;
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
            stp_reg <= stp_next;
        end
    end

    // A stopped parse leaves the offset alone until the next buffer start.
    a_stopped_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stp_reg && !first_of_buffer) |=> $stable(off_reg))
        else $error("offset moved while the parse was stopped");

    // A truncated result always stops the parse.
    a_trunc_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.kind == tlv_pkg::KIND_TRUNC)) |=> stp_reg)
        else $error("truncated result without stop");

    // The length field has four bytes.
    a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ph_reg == tlv_pkg::PH_LEN) |-> (cnt_reg < 32'(tlv_pkg::HDR_LEN_BYTES)))
        else $error("length byte count out of range");

endmodule

@@ design/tlv_obuf.sv @@
// ----------------------------------------------------------------------------
// tlv_obuf
// Two-entry result buffer that decouples the parser from the output stream.
// ----------------------------------------------------------------------------
module tlv_obuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tlv_pkg::tlv_result_t push_data,
    output logic                 not_full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tlv_pkg::tlv_result_t out_data
);

    tlv_pkg::tlv_result_t slot0_reg, slot0_next;
    tlv_pkg::tlv_result_t slot1_reg, slot1_next;
    logic [1:0]           count_reg, count_next;
    logic                 pop;

    assign out_valid = count_reg != 2'd0;
    assign not_full  = count_reg != 2'd2;
    assign out_data  = slot0_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ design/tlv_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tlv_stream_parser_unit
// TLV record parser: one buffer byte per input word, records with a one-byte
// tag and a four-byte little-endian length, decoded into result words.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: data_byte; tuser: first_of_buffer
// m_*      out  m_tvalid/m_tready  tdata: tag, length, int_value, value_byte;
//                                  tuser: kind; tlast: last_of_record
// apb      in   psel/penable       buffer_length at byte address 0
//
// One input word is accepted every cycle while the result buffer has room. The
// parse state updates on acceptance; results reach the master side through the
// registered two-word buffer, letting input go on while a result waits; input
// stalls only when both entries are full. Reset clears the parse state, the
// buffer length and the result buffer at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tlv_stream_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] first_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] tag, [39:8] length, [71:40] int_value,
                                   // [79:72] value_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 accept;
    logic                 buf_not_full;
    logic                 res_valid;
    logic [31:0]          buffer_length;
    tlv_pkg::tlv_result_t res;
    tlv_pkg::tlv_result_t head;

    assign s_tready = buf_not_full;
    assign accept   = s_tvalid && s_tready;

    tlv_apb u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .buffer_length (buffer_length)
    );

    tlv_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (s_tdata),
        .first_of_buffer (s_tuser[0]),
        .buffer_length   (buffer_length),
        .res_valid       (res_valid),
        .res             (res)
    );

    tlv_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .not_full  (buf_not_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {head.value_byte, head.int_value, head.length, head.tag};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_record;

endmodule
